### hw/rtl/mrc_pkg.sv
// Shared types and constants for the max reachable circle graph core.
// No dependencies; the other files except mrc_ram refer to it by scoped names.
package mrc_pkg;

    localparam int DEF_MAX_POINTS = 64;
    localparam int DEF_COORD_BITS = 16;
    localparam int IN_BITS        = 16;
    localparam int OUT_BITS       = 7;
    localparam int OUT_SAT        = 127;
    // point index as carried in the queue, wide enough for stores of up to 256 points
    localparam int IDX_BITS       = 8;

    typedef struct packed {
        logic [IN_BITS-1:0]  x;
        logic [IN_BITS-1:0]  y;
        logic [IN_BITS-1:0]  r;
        logic [IDX_BITS-1:0] idx;
        logic                store;
        logic                last;
        logic                ovf;
    } t_item;

    // queue to engine handshake
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_qout;

endpackage

### hw/rtl/max_reachable_circle_graph_core.sv
// Top level of the max reachable circle graph core: front end, item queue
// and compute engine. Uses mrc_pkg, mrc_front and mrc_engine (which uses mrc_ram).
//
//  channel   dir  handshake               payload
//  item      in   start & !busy           i_point_x, i_point_y, i_point_radius, i_last_point
//  result    out  o_valid (1-cycle strobe) o_max_reached, o_overflowed
//
// Each stored point passes through one pipelined distance unit, which compares it
// against every earlier point of the set.
// After the last point the closure runs: per start point, a setup state, then
// sweeps over the reach matrix RAM until a sweep adds nothing.
// A two-entry queue decouples intake; busy rises only while it is full.
// Reset is synchronous; the point and matrix RAMs need no clearing.
// Results cannot be held off; each strobe lasts exactly one cycle.
module max_reachable_circle_graph_core #(
    parameter int MAX_POINTS = mrc_pkg::DEF_MAX_POINTS,
    parameter int COORD_BITS = mrc_pkg::DEF_COORD_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [mrc_pkg::IN_BITS-1:0]   i_point_x,
    input  logic [mrc_pkg::IN_BITS-1:0]   i_point_y,
    input  logic [mrc_pkg::IN_BITS-1:0]   i_point_radius,
    input  logic                          i_last_point,
    output logic                          o_valid,
    output logic [mrc_pkg::OUT_BITS-1:0]  o_max_reached,
    output logic                          o_overflowed
);

    mrc_pkg::t_qout w_q;
    logic           w_pop;

    mrc_front #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_point_x      (i_point_x),
        .i_point_y      (i_point_y),
        .i_point_radius (i_point_radius),
        .i_last_point   (i_last_point),
        .o_q            (w_q),
        .i_pop          (w_pop)
    );

    mrc_engine #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q           (w_q),
        .o_pop         (w_pop),
        .o_valid       (o_valid),
        .o_max_reached (o_max_reached),
        .o_overflowed  (o_overflowed)
    );

    a_reach_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_max_reached != '0))
        else $error("result with empty reachable set");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q.valid)
        else $error("engine popped an empty queue");

endmodule

### hw/rtl/mrc_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module mrc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/mrc_front.sv
// Front end: accepts items, assigns store slots, tracks overflow, and
// queues classified items for the engine. Uses mrc_pkg.
module mrc_front #(
    parameter int MAX_POINTS = mrc_pkg::DEF_MAX_POINTS,
    parameter int COORD_BITS = mrc_pkg::DEF_COORD_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [mrc_pkg::IN_BITS-1:0]  i_point_x,
    input  logic [mrc_pkg::IN_BITS-1:0]  i_point_y,
    input  logic [mrc_pkg::IN_BITS-1:0]  i_point_radius,
    input  logic                         i_last_point,
    output mrc_pkg::t_qout               o_q,
    input  logic                         i_pop
);

    localparam int N  = MAX_POINTS;
    localparam int IW = $clog2(N);
    localparam int CW = $clog2(N + 1);
    localparam int CB = (COORD_BITS < mrc_pkg::IN_BITS) ? COORD_BITS : mrc_pkg::IN_BITS;
    localparam logic [mrc_pkg::IN_BITS-1:0] MASK =
        mrc_pkg::IN_BITS'((33'd1 << CB) - 33'd1);

    logic [CW-1:0]  r_count, n_count;
    logic           r_ovf, n_ovf;
    mrc_pkg::t_item r_q [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_num;
    logic           w_acc, w_store;
    mrc_pkg::t_item w_item;

    assign busy    = (r_num == 2'd2);
    assign w_acc   = start && !busy;
    assign w_store = (r_count < CW'(N));

    always_comb begin
        w_item.x     = i_point_x & MASK;
        w_item.y     = i_point_y & MASK;
        w_item.r     = i_point_radius & MASK;
        w_item.idx   = mrc_pkg::IDX_BITS'(r_count[IW-1:0]);
        w_item.store = w_store;
        w_item.last  = i_last_point;
        w_item.ovf   = r_ovf | !w_store;
        n_count      = r_count;
        n_ovf        = r_ovf;
        if (w_acc) begin
            if (i_last_point) begin
                n_count = '0;
                n_ovf   = 1'b0;
            end else begin
                n_ovf = w_item.ovf;
                if (w_store) begin
                    n_count = r_count + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_num   <= 2'd0;
        end else begin
            r_count <= n_count;
            r_ovf   <= n_ovf;
            if (w_acc) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_num <= r_num + {1'b0, w_acc} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_q[r_wp] <= w_item;
        end
    end

    assign o_q.valid = (r_num != 2'd0);
    assign o_q.item  = r_q[r_rp];

endmodule

### hw/rtl/mrc_engine.sv
// Back end: stores points, builds reach rows with a pipelined distance unit,
// then runs the closure sweeps per start point. Uses mrc_pkg and mrc_ram.
module mrc_engine #(
    parameter int MAX_POINTS = mrc_pkg::DEF_MAX_POINTS,
    parameter int COORD_BITS = mrc_pkg::DEF_COORD_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mrc_pkg::t_qout                i_q,
    output logic                          o_pop,
    output logic                          o_valid,
    output logic [mrc_pkg::OUT_BITS-1:0]  o_max_reached,
    output logic                          o_overflowed
);

    localparam int N  = MAX_POINTS;
    localparam int IW = $clog2(N);
    localparam int CW = $clog2(N + 1);
    localparam int CB = (COORD_BITS < mrc_pkg::IN_BITS) ? COORD_BITS : mrc_pkg::IN_BITS;
    localparam int SW = 2 * CB;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_ROW   = 3'd2;
    localparam logic [2:0] ST_CINIT = 3'd3;
    localparam logic [2:0] ST_SWEEP = 3'd4;

    logic [2:0]    r_state, n_state;
    logic [CB-1:0] r_x, r_y;
    logic [SW-1:0] r_rr;
    logic [IW-1:0] r_idx;
    logic          r_last, r_ovf;
    logic [CW-1:0] r_ka, n_ka;
    logic          r_v1, r_v2, r_v3;
    logic [IW-1:0] r_k1, r_k2, r_k3;
    logic [CB-1:0] r_dx, r_dy, r_rk;
    logic [SW-1:0] r_dx2, r_dy2, r_rk2;
    logic [N-1:0]  r_row, r_col;
    logic [CW-1:0] r_cnt, r_s, r_pc, r_best;
    logic [N-1:0]  r_set, n_set;
    logic          r_dv, r_grew;
    logic [IW-1:0] r_kd;
    logic          r_valid;
    logic [mrc_pkg::OUT_BITS-1:0] r_max;
    logic          r_oflag;

    logic            w_pwe, w_mwe, w_iss_scan, w_iss_sweep;
    logic [3*CB-1:0] w_prd;
    logic [2*N-1:0]  w_mrd;
    logic [IW-1:0]   w_praddr;
    logic [CB-1:0]   w_px, w_py, w_pr;
    logic [SW:0]     w_d;
    logic [N-1:0]    w_rowk, w_colk, w_onehot;
    logic            w_sk, w_sweep_end, w_grow;
    logic [CW-1:0]   w_pc_fin, w_best;

    mrc_ram #(.WIDTH(3 * CB), .DEPTH(N)) u_points (
        .i_clk   (i_clk),
        .i_we    (w_pwe),
        .i_waddr (i_q.item.idx[IW-1:0]),
        .i_wdata ({i_q.item.r[CB-1:0], i_q.item.y[CB-1:0], i_q.item.x[CB-1:0]}),
        .i_raddr (w_praddr),
        .o_rdata (w_prd)
    );

    // row word: upper half holds who reaches this point among earlier ones,
    // lower half holds which earlier points this one reaches, plus itself
    mrc_ram #(.WIDTH(2 * N), .DEPTH(N)) u_matrix (
        .i_clk   (i_clk),
        .i_we    (w_mwe),
        .i_waddr (r_idx),
        .i_wdata ({r_col, r_row | ({{(N-1){1'b0}}, 1'b1} << r_idx)}),
        .i_raddr (r_ka[IW-1:0]),
        .o_rdata (w_mrd)
    );

    assign o_pop       = (r_state == ST_IDLE) && i_q.valid;
    assign w_pwe       = o_pop && i_q.item.store;
    assign w_mwe       = (r_state == ST_ROW);
    assign w_iss_scan  = (r_state == ST_SCAN) && (r_ka < CW'(r_idx));
    assign w_iss_sweep = (r_state == ST_SWEEP) && (r_ka < r_cnt);
    assign w_praddr    = r_ka[IW-1:0];

    assign w_px = w_prd[CB-1:0];
    assign w_py = w_prd[2*CB-1:CB];
    assign w_pr = w_prd[3*CB-1:2*CB];
    assign w_d  = {1'b0, r_dx2} + {1'b0, r_dy2};

    // closure step on the row fetched for point r_kd
    assign w_rowk      = w_mrd[N-1:0];
    assign w_colk      = w_mrd[2*N-1:N];
    assign w_sk        = r_set[r_kd];
    assign w_onehot    = {{(N-1){1'b0}}, 1'b1} << r_kd;
    assign w_sweep_end = r_dv && (CW'(r_kd) == r_cnt - CW'(1));
    assign w_pc_fin    = r_pc + CW'(w_sk);
    assign w_best      = (w_pc_fin > r_best) ? w_pc_fin : r_best;

    always_comb begin
        n_set = r_set;
        if (r_dv) begin
            if (w_sk) begin
                n_set = n_set | w_rowk;
            end
            if ((w_colk & r_set) != '0) begin
                n_set = n_set | w_onehot;
            end
        end
        w_grow = (n_set != r_set);
    end

    always_comb begin
        n_state = r_state;
        n_ka    = r_ka;
        unique case (r_state)
            ST_IDLE: begin
                n_ka = '0;
                if (i_q.valid) begin
                    if (i_q.item.store) begin
                        n_state = ST_SCAN;
                    end else if (i_q.item.last) begin
                        n_state = ST_CINIT;
                    end
                end
            end
            ST_SCAN: begin
                if (w_iss_scan) begin
                    n_ka = r_ka + CW'(1);
                end else if (!r_v1 && !r_v2 && !r_v3) begin
                    n_state = ST_ROW;
                end
            end
            ST_ROW: begin
                n_state = r_last ? ST_CINIT : ST_IDLE;
            end
            ST_CINIT: begin
                n_ka    = '0;
                n_state = ST_SWEEP;
            end
            ST_SWEEP: begin
                if (w_iss_sweep) begin
                    n_ka = r_ka + CW'(1);
                end
                if (w_sweep_end) begin
                    if (r_grew || w_grow) begin
                        n_ka = '0;
                    end else if (r_s == r_cnt - CW'(1)) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_CINIT;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ka    <= '0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_dv    <= 1'b0;
            r_valid <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_ka    <= n_ka;
            r_v1    <= w_iss_scan;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_dv    <= w_iss_sweep;
            r_valid <= (r_state == ST_SWEEP) && w_sweep_end && !(r_grew || w_grow)
                       && (r_s == r_cnt - CW'(1));
            if (r_state == ST_ROW) begin
                r_cnt <= CW'(r_idx) + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_x    <= i_q.item.x[CB-1:0];
            r_y    <= i_q.item.y[CB-1:0];
            r_rr   <= SW'(i_q.item.r[CB-1:0]) * SW'(i_q.item.r[CB-1:0]);
            r_idx  <= i_q.item.idx[IW-1:0];
            r_last <= i_q.item.last;
            r_ovf  <= i_q.item.ovf;
            r_row  <= '0;
            r_col  <= '0;
        end
        // distance pipeline: fetch, differences, squares, compare
        r_k1  <= r_ka[IW-1:0];
        r_k2  <= r_k1;
        r_k3  <= r_k2;
        r_dx  <= (r_x >= w_px) ? (r_x - w_px) : (w_px - r_x);
        r_dy  <= (r_y >= w_py) ? (r_y - w_py) : (w_py - r_y);
        r_rk  <= w_pr;
        r_dx2 <= SW'(r_dx) * SW'(r_dx);
        r_dy2 <= SW'(r_dy) * SW'(r_dy);
        r_rk2 <= SW'(r_rk) * SW'(r_rk);
        if (r_v3) begin
            r_row[r_k3] <= (w_d <= {1'b0, r_rr});
            r_col[r_k3] <= (w_d <= {1'b0, r_rk2});
        end
        // closure sweeps
        r_kd <= r_ka[IW-1:0];
        if (r_state == ST_ROW) begin
            r_s    <= '0;
            r_best <= '0;
        end
        if (r_state == ST_IDLE && o_pop && !i_q.item.store && i_q.item.last) begin
            r_s    <= '0;
            r_best <= '0;
        end
        if (r_state == ST_CINIT) begin
            r_set  <= {{(N-1){1'b0}}, 1'b1} << r_s[IW-1:0];
            r_grew <= 1'b0;
            r_pc   <= '0;
        end else if (r_state == ST_SWEEP) begin
            r_set <= n_set;
            if (w_sweep_end) begin
                r_grew <= 1'b0;
                r_pc   <= '0;
                if (!(r_grew || w_grow)) begin
                    r_best <= w_best;
                    r_s    <= r_s + CW'(1);
                    if (32'(w_best) > 32'(mrc_pkg::OUT_SAT)) begin
                        r_max <= mrc_pkg::OUT_BITS'(mrc_pkg::OUT_SAT);
                    end else begin
                        r_max <= mrc_pkg::OUT_BITS'(w_best);
                    end
                    r_oflag <= r_ovf;
                end
            end else if (r_dv) begin
                r_grew <= r_grew | w_grow;
                r_pc   <= w_pc_fin;
            end
        end
    end

    assign o_valid       = r_valid;
    assign o_max_reached = r_max;
    assign o_overflowed  = r_oflag;

endmodule
